/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FMTP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmtp check failed");

// next-cycle implication
`define FMTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmtp check failed");

`endif

/* design/fmtp_pkg.sv */
// ---------------------------------------------------------------------------
// fmtp_pkg
// types, codes and helpers of the queue with tenfold purge
// ---------------------------------------------------------------------------
package fmtp_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam cnt_t CNT_ONE  = cnt_t'(1);
  localparam cnt_t CNT_ZERO = cnt_t'(0);
  localparam cnt_t CNT_FULL = cnt_t'(QUEUE_DEPTH);

  localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PURGE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic [COUNT_W-1:0]       removed_count;
    logic                     last;
  } out_res_t;

  typedef struct packed {
    logic                     tenfold;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     idx;
  } cell_ctrl_t;

  // |v| % 10 == 0: even, and v mod 5 is 0 (non-negative) or 1 (negative,
  // since 2^32 mod 10 is 6); 16 = 1 mod 5 so nibbles fold by plain sums
  function automatic logic is_tenfold(input logic [DATA_W-1:0] v);
    logic [6:0] s;
    logic [4:0] r;
    s = '0;
    for (int k = 0; k < DATA_W / 4; k++) begin
      s = s + 7'(v[4*k +: 4]);
    end
    r = 5'(s[6:4]) + 5'(s[3:0]);
    if (r >= 5'd10) r = r - 5'd10;
    if (r >= 5'd5) r = r - 5'd5;
    if (r >= 5'd5) r = r - 5'd5;
    return !v[0] && (r == (v[DATA_W-1] ? 5'd1 : 5'd0));
  endfunction

endpackage

/* design/fifo_with_multiple_of_ten_purge_unit.sv */
// ---------------------------------------------------------------------------
// fifo_with_multiple_of_ten_purge_unit
// bounded queue of signed words held in a row of slots, front at slot 0
// ---------------------------------------------------------------------------
//  port group | dir | handshake          | payload
//  in_        | in  | in_valid/in_stall  | in_req  (command, value)
//  out_       | out | out_valid/out_stall| out_res (status, element,
//             |     |                    |          removed_count, last)
//
//  enqueue and dequeue: result registered; a new request is taken whenever the
//  output is free. purge and dump: one step per held entry, the slot row moving
//  one place per cycle unless a stalled result holds it; no request meanwhile
//  reset clears the occupancy count and the output valid flag; the output
//  payload register and slot contents are not cleared
//  a stalled result holds the output register; dump waits on each result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_with_multiple_of_ten_purge_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fmtp_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output fmtp_pkg::out_res_t out_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PURGE,
    S_DUMP
  } state_t;

  state_t             state_r, state_nxt;
  fmtp_pkg::cnt_t     occ_r, occ_nxt;
  fmtp_pkg::cnt_t     steps_r, steps_nxt;
  fmtp_pkg::cnt_t     removed_r, removed_nxt;
  logic               out_valid_r, out_valid_nxt;
  fmtp_pkg::out_res_t out_res_r, out_res_nxt;

  fmtp_pkg::cell_ctrl_t ctrl;
  fmtp_pkg::entry_t     load_entry;
  fmtp_pkg::entry_t     entry_q [fmtp_pkg::QUEUE_DEPTH];
  fmtp_pkg::entry_t     right_w [fmtp_pkg::QUEUE_DEPTH];
  fmtp_pkg::entry_t     head;
  fmtp_pkg::cnt_t       occ_dec;
  logic                 out_free;
  logic                 in_acc;
  logic                 out_load;
  logic                 enq_ok;
  logic                 dump_done;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign in_acc     = in_valid && !in_stall;
  assign head       = entry_q[0];
  assign occ_dec    = occ_r - fmtp_pkg::CNT_ONE;
  assign load_entry = '{tenfold: fmtp_pkg::is_tenfold(in_req.value), data: in_req.value};
  assign enq_ok     = in_acc && (in_req.command == fmtp_pkg::CMD_ENQ) &&
                      (occ_r != fmtp_pkg::CNT_FULL);
  assign dump_done  = (state_r == S_DUMP) && out_load && out_res_nxt.last;

  always_comb begin
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    steps_nxt   = steps_r;
    removed_nxt = removed_r;
    out_load    = 1'b0;
    out_res_nxt = out_res_r;
    ctrl.op     = fmtp_pkg::CELL_HOLD;
    ctrl.idx    = occ_dec[fmtp_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_load    = 1'b1;
          out_res_nxt = '{status: fmtp_pkg::ST_OK, element: '0, removed_count: '0,
                          last: 1'b1};
          case (in_req.command)
            fmtp_pkg::CMD_ENQ: begin
              if (occ_r == fmtp_pkg::CNT_FULL) begin
                out_res_nxt.status = fmtp_pkg::ST_OVER;
              end else begin
                ctrl.op  = fmtp_pkg::CELL_LOAD;
                ctrl.idx = occ_r[fmtp_pkg::IDX_W-1:0];
                occ_nxt  = occ_r + fmtp_pkg::CNT_ONE;
              end
            end
            fmtp_pkg::CMD_DEQ: begin
              if (occ_r == fmtp_pkg::CNT_ZERO) begin
                out_res_nxt.status = fmtp_pkg::ST_UNDER;
              end else begin
                out_res_nxt.element = head.data;
                ctrl.op = fmtp_pkg::CELL_SHIFT;
                occ_nxt = occ_dec;
              end
            end
            fmtp_pkg::CMD_PURGE: begin
              if (occ_r == fmtp_pkg::CNT_ZERO) begin
                out_res_nxt.status = fmtp_pkg::ST_UNDER;
              end else begin
                out_load    = 1'b0;
                state_nxt   = S_PURGE;
                steps_nxt   = occ_r;
                removed_nxt = fmtp_pkg::CNT_ZERO;
              end
            end
            default: begin
              if (occ_r == fmtp_pkg::CNT_ZERO) begin
                out_res_nxt.status = fmtp_pkg::ST_UNDER;
              end else begin
                out_load  = 1'b0;
                state_nxt = S_DUMP;
                steps_nxt = occ_r;
              end
            end
          endcase
        end
      end
      S_PURGE: begin
        // the final step needs room in the output register
        if (steps_r != fmtp_pkg::CNT_ONE || out_free) begin
          if (head.tenfold) begin
            ctrl.op     = fmtp_pkg::CELL_SHIFT;
            occ_nxt     = occ_dec;
            removed_nxt = removed_r + fmtp_pkg::CNT_ONE;
          end else begin
            ctrl.op = fmtp_pkg::CELL_ROTATE;
          end
          steps_nxt = steps_r - fmtp_pkg::CNT_ONE;
          if (steps_r == fmtp_pkg::CNT_ONE) begin
            out_load    = 1'b1;
            out_res_nxt = '{status: fmtp_pkg::ST_OK, element: '0,
                            removed_count: fmtp_pkg::count_t'(removed_nxt),
                            last: 1'b1};
            state_nxt   = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.op     = fmtp_pkg::CELL_ROTATE;
          out_load    = 1'b1;
          out_res_nxt = '{status: fmtp_pkg::ST_OK, element: head.data, removed_count: '0,
                          last: (steps_r == fmtp_pkg::CNT_ONE)};
          steps_nxt   = steps_r - fmtp_pkg::CNT_ONE;
          if (steps_r == fmtp_pkg::CNT_ONE) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= fmtp_pkg::CNT_ZERO;
      steps_r     <= fmtp_pkg::CNT_ZERO;
      removed_r   <= fmtp_pkg::CNT_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      steps_r     <= steps_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  for (genvar i = 0; i < fmtp_pkg::QUEUE_DEPTH; i++) begin : g_cell
    if (i < fmtp_pkg::QUEUE_DEPTH - 1) begin : g_mid
      assign right_w[i] = entry_q[i+1];
    end else begin : g_end
      assign right_w[i] = '0;
    end

    fmtp_cell u_cell (
      .clk         (clk),
      .cell_idx    (fmtp_pkg::idx_t'(i)),
      .ctrl        (ctrl),
      .load_entry  (load_entry),
      .right_entry (right_w[i]),
      .head_entry  (head),
      .entry_q     (entry_q[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `FMTP_ASSERT_IMPLIES(a_occ_bound, 1'b1, occ_r <= fmtp_pkg::CNT_FULL)
  `FMTP_ASSERT_IMPLIES(a_purge_steps, state_r == S_PURGE, steps_r <= occ_r)
  `FMTP_ASSERT_NEXT(a_enq_grows, enq_ok, occ_r == $past(occ_r) + fmtp_pkg::CNT_ONE)
  `FMTP_ASSERT_NEXT(a_dump_ends, dump_done, state_r == S_IDLE)

endmodule

/* design/fmtp_cell.sv */
// ---------------------------------------------------------------------------
// fmtp_cell
// one queue slot: loads, shifts toward the front or takes the head entry
// ---------------------------------------------------------------------------
module fmtp_cell (
  input  logic                 clk,
  input  fmtp_pkg::idx_t       cell_idx,
  input  fmtp_pkg::cell_ctrl_t ctrl,
  input  fmtp_pkg::entry_t     load_entry,
  input  fmtp_pkg::entry_t     right_entry,
  input  fmtp_pkg::entry_t     head_entry,
  output fmtp_pkg::entry_t     entry_q
);

  fmtp_pkg::entry_t entry_r;
  fmtp_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      fmtp_pkg::CELL_LOAD: begin
        if (cell_idx == ctrl.idx) entry_nxt = load_entry;
      end
      fmtp_pkg::CELL_SHIFT: begin
        if (cell_idx < ctrl.idx) entry_nxt = right_entry;
      end
      fmtp_pkg::CELL_ROTATE: begin
        // tail slot takes the old head, the slots before it move up
        if (cell_idx < ctrl.idx) begin
          entry_nxt = right_entry;
        end else if (cell_idx == ctrl.idx) begin
          entry_nxt = head_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule
